>>> design/lqdm_pkg.sv
// Shared types, constants and helper functions for the link quality degradation monitor.
// Used by link_quality_degradation_monitor_core. No dependencies.

package lqdm_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned LIM_W   = 16;
  localparam int unsigned LOSS_W  = 7;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned PROD_W  = 23;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  localparam logic [PROD_W-1:0] LOSS_SCALE = PROD_W'(100);

  typedef logic [2:0] req_t;
  localparam req_t REQ_SAMPLE  = 3'd0;
  localparam req_t REQ_STATE   = 3'd1;
  localparam req_t REQ_VERSION = 3'd2;
  localparam req_t REQ_RESYNC  = 3'd3;
  localparam req_t REQ_CLOSE   = 3'd4;
  localparam req_t REQ_TICK    = 3'd5;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_RTT_LIMIT  = 3'd0;
  localparam reg_idx_t REG_JIT_LIMIT  = 3'd1;
  localparam reg_idx_t REG_LOSS_LIMIT = 3'd2;
  localparam reg_idx_t REG_MAX_AGE    = 3'd3;
  localparam reg_idx_t REG_STALE_DLY  = 3'd4;
  localparam reg_idx_t REG_NET_DLY    = 3'd5;
  localparam reg_idx_t REG_RECOV_DLY  = 3'd6;

  localparam logic [LIM_W-1:0]  RST_RTT_LIMIT  = LIM_W'(100);
  localparam logic [LIM_W-1:0]  RST_JIT_LIMIT  = LIM_W'(30);
  localparam logic [LOSS_W-1:0] RST_LOSS_LIMIT = LOSS_W'(1);
  localparam logic [LIM_W-1:0]  RST_MAX_AGE    = LIM_W'(100);
  localparam logic [LIM_W-1:0]  RST_STALE_DLY  = LIM_W'(500);
  localparam logic [LIM_W-1:0]  RST_NET_DLY    = LIM_W'(500);
  localparam logic [LIM_W-1:0]  RST_RECOV_DLY  = LIM_W'(1000);

  // True when a sample is within the round-trip, jitter and loss budgets.
  function automatic logic net_ok(
    input logic [CNT_W-1:0]  rtt,
    input logic [CNT_W-1:0]  jit,
    input logic [CNT_W-1:0]  sent,
    input logic [CNT_W-1:0]  lost,
    input logic [LIM_W-1:0]  rtt_lim,
    input logic [LIM_W-1:0]  jit_lim,
    input logic [LOSS_W-1:0] loss_lim
  );
    logic [PROD_W-1:0] lhs;
    logic [PROD_W-1:0] rhs;
    lhs = PROD_W'(lost) * LOSS_SCALE;
    rhs = PROD_W'(loss_lim) * PROD_W'(sent);
    return (rtt <= rtt_lim) && (jit <= jit_lim) && (lhs <= rhs);
  endfunction

endpackage

>>> design/link_quality_degradation_monitor_core.sv
// Link quality degradation monitor: event checks, staleness and degraded-flag logic.
// Depends on lqdm_pkg for widths, request and register codes and the budget check.
//
// Usage: each item on the in_ channel is one timestamped event (network sample,
// state report with age, version-only report, resync, transport close or tick).
// Every accepted item yields exactly one item on the out_ channel carrying the
// accepted bit and the link flags, version and jitter after the update.
// The result is valid in the cycle after acceptance. One item is taken per cycle
// while results are taken; the update is one pass of compare and add logic from
// the input ports into the state and result registers. in_ready is high whenever
// the result register is empty or being taken, so a stalled receiver holds the
// current result and stops acceptance until it is taken. Limits and delays are
// written through the APB port while the block is idle; the user must see to it,
// as the block does not enforce it. Synchronous reset clears flags, time validity
// bits and the result register and loads the default limits, with no clearing pass.

module link_quality_degradation_monitor_core
  import lqdm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_req_type,
  input  logic [TIME_W-1:0]   in_time_ms,
  input  logic [CNT_W-1:0]    in_rtt_ms,
  input  logic [CNT_W-1:0]    in_sent_packets,
  input  logic [CNT_W-1:0]    in_lost_packets,
  input  logic [TIME_W-1:0]   in_version,
  input  logic [TIME_W-1:0]   in_state_age_ms,

  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_accepted,
  output logic                out_degraded,
  output logic                out_resyncing,
  output logic                out_reconnect_flag,
  output logic                out_state_current,
  output logic                out_retaining_last,
  output logic [TIME_W-1:0]   out_accepted_version,
  output logic [CNT_W-1:0]    out_jitter_ms,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  logic [LIM_W-1:0]  rtt_lim_r, jit_lim_r, max_age_r, stale_dly_r, net_dly_r, recov_dly_r;
  logic [LOSS_W-1:0] loss_lim_r;
  reg_idx_t          cfg_idx;
  logic              cfg_we;

  logic [CNT_W-1:0]  last_rtt_r, last_sent_r, last_lost_r, jitter_r;
  logic [CNT_W-1:0]  last_rtt_nxt, last_sent_nxt, last_lost_nxt, jitter_nxt;
  logic              have_r, have_nxt;
  logic [TIME_W-1:0] sample_time_r, sample_time_nxt;
  logic [TIME_W-1:0] net_since_r, net_since_nxt;
  logic              net_exc_ok_r, net_exc_ok_nxt;
  logic [TIME_W-1:0] latest_ver_r, latest_ver_nxt;
  logic [32:0]       produced_at_r, produced_at_nxt;
  logic              produced_ok_r, produced_ok_nxt;
  logic [TIME_W-1:0] accepted_at_r, accepted_at_nxt;
  logic              accepted_ok_r, accepted_ok_nxt;
  logic [32:0]       stale_since_r, stale_since_nxt;
  logic              stale_ok_r, stale_ok_nxt;
  logic [TIME_W-1:0] sup_since_r, sup_since_nxt;
  logic              sup_ok_r, sup_ok_nxt;
  logic              resync_r, resync_nxt;
  logic              reconn_r, reconn_nxt;
  logic              degraded_r, degraded_nxt;
  logic              out_valid_r;
  logic              out_acc_r, acc_nxt;

  logic              accept;
  logic signed [33:0] now_s;
  logic signed [32:0] produced_in;
  logic signed [33:0] stale_in_sum;
  logic signed [33:0] prod_x;
  logic signed [33:0] thr;
  logic signed [33:0] stale_end;
  logic [32:0]       net_end;
  logic [32:0]       sup_end;
  logic [32:0]       now_u;
  logic [CNT_W-1:0]  jit_in;
  logic              samp_ok, samp_inside, stored_inside;
  logic              ver_lt, ver_eq, late_acc, state_ok, version_ok;
  logic              state_gate, state_in, stale_set, stale_ok_eff;
  logic [32:0]       stale_eff;
  logic              stale_long, net_long, degraded_mid, full;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rtt_lim_r   <= RST_RTT_LIMIT;
      jit_lim_r   <= RST_JIT_LIMIT;
      loss_lim_r  <= RST_LOSS_LIMIT;
      max_age_r   <= RST_MAX_AGE;
      stale_dly_r <= RST_STALE_DLY;
      net_dly_r   <= RST_NET_DLY;
      recov_dly_r <= RST_RECOV_DLY;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_RTT_LIMIT:  rtt_lim_r   <= pwdata[LIM_W-1:0];
        REG_JIT_LIMIT:  jit_lim_r   <= pwdata[LIM_W-1:0];
        REG_LOSS_LIMIT: loss_lim_r  <= pwdata[LOSS_W-1:0];
        REG_MAX_AGE:    max_age_r   <= pwdata[LIM_W-1:0];
        REG_STALE_DLY:  stale_dly_r <= pwdata[LIM_W-1:0];
        REG_NET_DLY:    net_dly_r   <= pwdata[LIM_W-1:0];
        REG_RECOV_DLY:  recov_dly_r <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_RTT_LIMIT:  prdata = DATA_W'(rtt_lim_r);
      REG_JIT_LIMIT:  prdata = DATA_W'(jit_lim_r);
      REG_LOSS_LIMIT: prdata = DATA_W'(loss_lim_r);
      REG_MAX_AGE:    prdata = DATA_W'(max_age_r);
      REG_STALE_DLY:  prdata = DATA_W'(stale_dly_r);
      REG_NET_DLY:    prdata = DATA_W'(net_dly_r);
      REG_RECOV_DLY:  prdata = DATA_W'(recov_dly_r);
      default:        prdata = '0;
    endcase
  end

  // Handshake.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Time arithmetic shared by the event paths.
  assign now_u        = {1'b0, in_time_ms};
  assign now_s        = $signed({2'b00, in_time_ms});
  assign produced_in  = $signed({1'b0, in_time_ms}) - $signed({1'b0, in_state_age_ms});
  assign stale_in_sum = $signed({produced_in[32], produced_in}) + $signed({18'd0, max_age_r});
  assign prod_x       = $signed({produced_at_r[32], produced_at_r});
  assign thr          = prod_x + $signed({18'd0, max_age_r});

  // Network sample checks.
  assign jit_in  = !have_r ? '0 :
                   (in_rtt_ms > last_rtt_r) ? in_rtt_ms - last_rtt_r : last_rtt_r - in_rtt_ms;
  assign samp_ok = (in_sent_packets != '0) && (in_lost_packets <= in_sent_packets) &&
                   !(have_r && (in_time_ms < sample_time_r));
  assign samp_inside   = net_ok(in_rtt_ms, jit_in, in_sent_packets, in_lost_packets,
                                rtt_lim_r, jit_lim_r, loss_lim_r);
  assign stored_inside = have_r && net_ok(last_rtt_r, jitter_r, last_sent_r, last_lost_r,
                                          rtt_lim_r, jit_lim_r, loss_lim_r);

  // State and version checks.
  assign ver_lt     = in_version < latest_ver_r;
  assign ver_eq     = in_version == latest_ver_r;
  assign late_acc   = accepted_ok_r && (in_time_ms < accepted_at_r);
  assign state_ok   = (in_version != '0) && !ver_lt && !(ver_eq && !resync_r && produced_ok_r) &&
                      !late_acc && !(produced_ok_r && (produced_in < $signed(produced_at_r)));
  assign version_ok = (in_version != '0) && !ver_lt && !(ver_eq && !resync_r) && !late_acc;

  // Tick evaluation.
  assign state_gate   = produced_ok_r && (now_s >= prod_x);
  assign state_in     = state_gate && (now_s <= thr);
  assign stale_set    = state_gate && !state_in && !stale_ok_r;
  assign stale_eff    = stale_set ? thr[32:0] : stale_since_r;
  assign stale_ok_eff = state_in ? 1'b0 : (stale_ok_r || stale_set);
  assign stale_end    = $signed({stale_eff[32], stale_eff}) + $signed({18'd0, stale_dly_r});
  assign stale_long   = stale_ok_eff && (now_s >= stale_end);
  assign net_end      = {1'b0, net_since_r} + {17'd0, net_dly_r};
  assign net_long     = net_exc_ok_r && (now_u >= net_end);
  assign sup_end      = {1'b0, sup_since_r} + {17'd0, recov_dly_r};
  assign degraded_mid = degraded_r || (!reconn_r && (stale_long || net_long));
  assign full         = !reconn_r && !resync_r && state_in && stored_inside;

  always_comb begin
    last_rtt_nxt    = last_rtt_r;
    last_sent_nxt   = last_sent_r;
    last_lost_nxt   = last_lost_r;
    jitter_nxt      = jitter_r;
    have_nxt        = have_r;
    sample_time_nxt = sample_time_r;
    net_since_nxt   = net_since_r;
    net_exc_ok_nxt  = net_exc_ok_r;
    latest_ver_nxt  = latest_ver_r;
    produced_at_nxt = produced_at_r;
    produced_ok_nxt = produced_ok_r;
    accepted_at_nxt = accepted_at_r;
    accepted_ok_nxt = accepted_ok_r;
    stale_since_nxt = stale_since_r;
    stale_ok_nxt    = stale_ok_r;
    sup_since_nxt   = sup_since_r;
    sup_ok_nxt      = sup_ok_r;
    resync_nxt      = resync_r;
    reconn_nxt      = reconn_r;
    degraded_nxt    = degraded_r;
    acc_nxt         = 1'b0;
    case (in_req_type)
      REQ_SAMPLE: begin
        if (samp_ok) begin
          acc_nxt         = 1'b1;
          jitter_nxt      = jit_in;
          last_rtt_nxt    = in_rtt_ms;
          last_sent_nxt   = in_sent_packets;
          last_lost_nxt   = in_lost_packets;
          have_nxt        = 1'b1;
          sample_time_nxt = in_time_ms;
          if (samp_inside) begin
            net_exc_ok_nxt = 1'b0;
          end else if (!net_exc_ok_r) begin
            net_since_nxt  = in_time_ms;
            net_exc_ok_nxt = 1'b1;
          end
        end
      end
      REQ_STATE: begin
        if (state_ok) begin
          acc_nxt         = 1'b1;
          latest_ver_nxt  = in_version;
          produced_at_nxt = produced_in;
          produced_ok_nxt = 1'b1;
          accepted_at_nxt = in_time_ms;
          accepted_ok_nxt = 1'b1;
          if (in_state_age_ms <= TIME_W'(max_age_r)) begin
            stale_ok_nxt = 1'b0;
          end else if (!stale_ok_r) begin
            stale_since_nxt = stale_in_sum[32:0];
            stale_ok_nxt    = 1'b1;
          end
          resync_nxt = 1'b0;
          reconn_nxt = 1'b0;
        end
      end
      REQ_VERSION: begin
        if (version_ok) begin
          acc_nxt         = 1'b1;
          latest_ver_nxt  = in_version;
          accepted_at_nxt = in_time_ms;
          accepted_ok_nxt = 1'b1;
          resync_nxt      = 1'b0;
          reconn_nxt      = 1'b0;
        end
      end
      REQ_RESYNC: begin
        resync_nxt = 1'b1;
        sup_ok_nxt = 1'b0;
      end
      REQ_CLOSE: begin
        reconn_nxt   = 1'b1;
        resync_nxt   = 1'b1;
        degraded_nxt = 1'b0;
        sup_ok_nxt   = 1'b0;
      end
      REQ_TICK: begin
        stale_since_nxt = stale_eff;
        stale_ok_nxt    = stale_ok_eff;
        degraded_nxt    = degraded_mid;
        if (degraded_mid && full) begin
          if (!sup_ok_r) begin
            sup_since_nxt = in_time_ms;
            sup_ok_nxt    = 1'b1;
          end else if (now_u >= sup_end) begin
            degraded_nxt = 1'b0;
          end
        end else begin
          sup_ok_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r        <= 1'b0;
      net_exc_ok_r  <= 1'b0;
      produced_ok_r <= 1'b0;
      accepted_ok_r <= 1'b0;
      stale_ok_r    <= 1'b0;
      sup_ok_r      <= 1'b0;
      resync_r      <= 1'b0;
      reconn_r      <= 1'b0;
      degraded_r    <= 1'b0;
      last_rtt_r    <= '0;
      last_sent_r   <= '0;
      last_lost_r   <= '0;
      jitter_r      <= '0;
      latest_ver_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (accept) begin
        have_r        <= have_nxt;
        net_exc_ok_r  <= net_exc_ok_nxt;
        produced_ok_r <= produced_ok_nxt;
        accepted_ok_r <= accepted_ok_nxt;
        stale_ok_r    <= stale_ok_nxt;
        sup_ok_r      <= sup_ok_nxt;
        resync_r      <= resync_nxt;
        reconn_r      <= reconn_nxt;
        degraded_r    <= degraded_nxt;
        last_rtt_r    <= last_rtt_nxt;
        last_sent_r   <= last_sent_nxt;
        last_lost_r   <= last_lost_nxt;
        jitter_r      <= jitter_nxt;
        latest_ver_r  <= latest_ver_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Time points, qualified by their valid bits.
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_time_r <= sample_time_nxt;
      net_since_r   <= net_since_nxt;
      produced_at_r <= produced_at_nxt;
      accepted_at_r <= accepted_at_nxt;
      stale_since_r <= stale_since_nxt;
      sup_since_r   <= sup_since_nxt;
      out_acc_r     <= acc_nxt;
    end
  end

  // The state registers change only when a new result is loaded, so the
  // result fields are read straight from them.
  assign out_valid            = out_valid_r;
  assign out_accepted         = out_acc_r;
  assign out_degraded         = degraded_r;
  assign out_resyncing        = resync_r;
  assign out_reconnect_flag   = reconn_r;
  assign out_state_current    = (latest_ver_r != '0) && !resync_r && !reconn_r;
  assign out_retaining_last   = resync_r && (latest_ver_r != '0);
  assign out_accepted_version = latest_ver_r;
  assign out_jitter_ms        = jitter_r;

`ifndef SYNTHESIS
  a_reconn_implies_resync: assert property (@(posedge clk) disable iff (!rst_n)
    reconn_r |-> resync_r)
    else $error("reconnect set without resync");

  a_close_clears_degraded: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req_type == REQ_CLOSE)) |=> (!degraded_r && reconn_r))
    else $error("close item did not clear degraded");

  a_version_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (latest_ver_r >= $past(latest_ver_r)))
    else $error("accepted version went backwards");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> ($stable(latest_ver_r) && $stable(degraded_r)))
    else $error("result changed while stalled");
`endif

endmodule
